/* rtl/core/height_color_ramp_core_macros.svh */
`ifndef HEIGHT_COLOR_RAMP_CORE_MACROS_SVH
`define HEIGHT_COLOR_RAMP_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define HCR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define HCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/hcr_pkg.sv */
`timescale 1ns / 1ps

package hcr_pkg;

  localparam int H_W     = 16;
  localparam int STEP_W  = 16;
  localparam int CNT_W   = 3;
  localparam int COLOR_W = 24;
  localparam int CH_W    = 8;
  localparam int NUM_W   = 24;
  localparam int IDX_W   = 3;
  localparam int CFG_W   = 24;
  localparam int NCH     = 3;

  // quotient bits resolved per pipeline stage
  localparam int BITS_PER_ST = 2;
  localparam int HDIV_ST     = H_W / BITS_PER_ST;
  localparam int CDIV_ST     = CH_W / BITS_PER_ST;

  localparam logic [IDX_W-1:0] REG_SEGMENT_STEP = 3'd0;
  localparam logic [IDX_W-1:0] REG_COLOR_COUNT  = 3'd1;
  localparam logic [IDX_W-1:0] REG_PALETTE_0    = 3'd2;

  typedef struct packed {
    logic              vld;
    logic [H_W-1:0]    num;
    logic [STEP_W-1:0] rem;
    logic [H_W-1:0]    quo;
  } hdiv_t;

  typedef struct packed {
    logic                       vld;
    logic                       sat;
    logic [COLOR_W-1:0]         satcol;
    logic [NCH-1:0][NUM_W-1:0]  pa;
    logic [NCH-1:0][NUM_W-1:0]  pb;
  } mul_t;

  typedef struct packed {
    logic                       vld;
    logic                       sat;
    logic [COLOR_W-1:0]         satcol;
    logic [NCH-1:0][NUM_W-1:0]  num;
  } sum_t;

  typedef struct packed {
    logic [STEP_W-1:0] rem;
    logic [CH_W-1:0]   low;
    logic [CH_W-1:0]   quo;
  } chdiv_t;

  typedef struct packed {
    logic                  vld;
    logic                  sat;
    logic [COLOR_W-1:0]    satcol;
    chdiv_t [NCH-1:0]      ch;
  } cdiv_t;

  function automatic hdiv_t hdiv_bit(hdiv_t x, logic [STEP_W-1:0] step);
    logic [STEP_W:0] ext;
    hdiv_t           y;
    y     = x;
    ext   = {x.rem, x.num[H_W-1]};
    y.num = {x.num[H_W-2:0], 1'b0};
    if (ext >= {1'b0, step}) begin
      y.rem = STEP_W'(ext - {1'b0, step});
      y.quo = {x.quo[H_W-2:0], 1'b1};
    end else begin
      y.rem = ext[STEP_W-1:0];
      y.quo = {x.quo[H_W-2:0], 1'b0};
    end
    return y;
  endfunction

  function automatic chdiv_t chdiv_bit(chdiv_t x, logic [STEP_W-1:0] step);
    logic [STEP_W:0] ext;
    chdiv_t          y;
    y     = x;
    ext   = {x.rem, x.low[CH_W-1]};
    y.low = {x.low[CH_W-2:0], 1'b0};
    if (ext >= {1'b0, step}) begin
      y.rem = STEP_W'(ext - {1'b0, step});
      y.quo = {x.quo[CH_W-2:0], 1'b1};
    end else begin
      y.rem = ext[STEP_W-1:0];
      y.quo = {x.quo[CH_W-2:0], 1'b0};
    end
    return y;
  endfunction

endpackage

/* rtl/core/height_color_ramp_core.sv */
`timescale 1ns / 1ps

// Height to RGB color ramp. One word per clock: start is taken on every cycle
// (busy stays low) and each result appears on out_valid with its three levels
// for exactly one cycle; the receiver cannot stall it. The pipeline is built
// around two restoring dividers, two quotient bits per stage: an input
// register, 8 stages for height / segment_step, then a multiply stage, an add
// stage, a staging register, 4 stages for the channel divide, and the output
// register. The user must write configuration only while no result is
// pending; the block itself does not enforce this.
`include "height_color_ramp_core_macros.svh"

module height_color_ramp_core
  import hcr_pkg::*;
#(
  parameter int MAX_COLORS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [H_W-1:0]     in_height_sample,
  output logic               out_valid,
  output logic [CH_W-1:0]    out_red_level,
  output logic [CH_W-1:0]    out_green_level,
  output logic [CH_W-1:0]    out_blue_level,
  input  logic               cfg_we,
  input  logic [IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data
);

  localparam int PW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;

  logic [STEP_W-1:0]  segment_step_r;
  logic [CNT_W-1:0]   color_count_r;
  logic [COLOR_W-1:0] palette_r [MAX_COLORS];

  logic [CNT_W-1:0]   cnt_clamp;
  logic [PW-1:0]      last_idx;

  hdiv_t hd_r   [HDIV_ST+1];
  hdiv_t hd_nxt [HDIV_ST+1];
  mul_t  mu_r, mu_nxt;
  sum_t  su_r, su_nxt;
  cdiv_t cd_r   [CDIV_ST+1];
  cdiv_t cd_nxt [CDIV_ST+1];

  logic            out_valid_r, out_valid_nxt;
  logic [CH_W-1:0] red_r, red_nxt;
  logic [CH_W-1:0] green_r, green_nxt;
  logic [CH_W-1:0] blue_r, blue_nxt;

  logic               hd_chk;
  logic               hd_rem_ok;
  logic               cd_chk;
  logic               cd_rem_ok;
  logic               cd_sat;
  logic [COLOR_W-1:0] out_rgb;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      segment_step_r <= STEP_W'(1);
      color_count_r  <= CNT_W'(6);
      for (int e = 0; e < MAX_COLORS; e++) begin
        palette_r[e] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == REG_SEGMENT_STEP) begin
        segment_step_r <= cfg_data[STEP_W-1:0];
      end
      if (cfg_index == REG_COLOR_COUNT) begin
        color_count_r <= cfg_data[CNT_W-1:0];
      end
      for (int e = 0; e < MAX_COLORS; e++) begin
        if (cfg_index == IDX_W'(int'(REG_PALETTE_0) + e)) begin
          palette_r[e] <= cfg_data[COLOR_W-1:0];
        end
      end
    end
  end

  always_comb begin
    if (color_count_r == '0) begin
      cnt_clamp = CNT_W'(1);
    end else if (color_count_r > CNT_W'(MAX_COLORS)) begin
      cnt_clamp = CNT_W'(MAX_COLORS);
    end else begin
      cnt_clamp = color_count_r;
    end
    last_idx = PW'(cnt_clamp - CNT_W'(1));
  end

  // height / step
  always_comb begin
    hd_nxt[0].vld = start;
    hd_nxt[0].num = in_height_sample;
    hd_nxt[0].rem = '0;
    hd_nxt[0].quo = '0;
    for (int k = 0; k < HDIV_ST; k++) begin
      hd_nxt[k+1] = hd_r[k];
      for (int b = 0; b < BITS_PER_ST; b++) begin
        hd_nxt[k+1] = hdiv_bit(hd_nxt[k+1], segment_step_r);
      end
    end
  end

  // segment lookup and weights
  always_comb begin
    logic [H_W-1:0]    q;
    logic [STEP_W-1:0] r;
    logic [STEP_W-1:0] w_lo;
    logic [PW-1:0]     idx;
    logic [PW-1:0]     idx_hi;
    logic [COLOR_W-1:0] lo;
    logic [COLOR_W-1:0] hi;
    q      = hd_r[HDIV_ST].quo;
    r      = hd_r[HDIV_ST].rem;
    w_lo   = segment_step_r - r;
    idx    = q[PW-1:0];
    idx_hi = (idx == PW'(MAX_COLORS - 1)) ? idx : idx + PW'(1);
    lo     = palette_r[idx];
    hi     = palette_r[idx_hi];
    mu_nxt.vld    = hd_r[HDIV_ST].vld;
    mu_nxt.sat    = (segment_step_r == '0) || (q >= H_W'(last_idx));
    mu_nxt.satcol = palette_r[last_idx];
    for (int c = 0; c < NCH; c++) begin
      mu_nxt.pa[c] = NUM_W'(lo[CH_W*c +: CH_W]) * NUM_W'(w_lo);
      mu_nxt.pb[c] = NUM_W'(hi[CH_W*c +: CH_W]) * NUM_W'(r);
    end
  end

  always_comb begin
    su_nxt.vld    = mu_r.vld;
    su_nxt.sat    = mu_r.sat;
    su_nxt.satcol = mu_r.satcol;
    for (int c = 0; c < NCH; c++) begin
      su_nxt.num[c] = mu_r.pa[c] + mu_r.pb[c];
    end
  end

  // channel / step, quotient known to fit 8 bits
  always_comb begin
    cd_nxt[0].vld    = su_r.vld;
    cd_nxt[0].sat    = su_r.sat;
    cd_nxt[0].satcol = su_r.satcol;
    for (int c = 0; c < NCH; c++) begin
      cd_nxt[0].ch[c].rem = su_r.num[c][NUM_W-1:CH_W];
      cd_nxt[0].ch[c].low = su_r.num[c][CH_W-1:0];
      cd_nxt[0].ch[c].quo = '0;
    end
    for (int k = 0; k < CDIV_ST; k++) begin
      cd_nxt[k+1] = cd_r[k];
      for (int c = 0; c < NCH; c++) begin
        for (int b = 0; b < BITS_PER_ST; b++) begin
          cd_nxt[k+1].ch[c] = chdiv_bit(cd_nxt[k+1].ch[c], segment_step_r);
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = cd_r[CDIV_ST].vld;
    if (cd_r[CDIV_ST].sat) begin
      red_nxt   = cd_r[CDIV_ST].satcol[23:16];
      green_nxt = cd_r[CDIV_ST].satcol[15:8];
      blue_nxt  = cd_r[CDIV_ST].satcol[7:0];
    end else begin
      red_nxt   = cd_r[CDIV_ST].ch[2].quo;
      green_nxt = cd_r[CDIV_ST].ch[1].quo;
      blue_nxt  = cd_r[CDIV_ST].ch[0].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= HDIV_ST; k++) begin
        hd_r[k].vld <= 1'b0;
      end
      mu_r.vld <= 1'b0;
      su_r.vld <= 1'b0;
      for (int k = 0; k <= CDIV_ST; k++) begin
        cd_r[k].vld <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      for (int k = 0; k <= HDIV_ST; k++) begin
        hd_r[k] <= hd_nxt[k];
      end
      mu_r <= mu_nxt;
      su_r <= su_nxt;
      for (int k = 0; k <= CDIV_ST; k++) begin
        cd_r[k] <= cd_nxt[k];
      end
      out_valid_r <= out_valid_nxt;
      red_r       <= red_nxt;
      green_r     <= green_nxt;
      blue_r      <= blue_nxt;
    end
  end

  assign busy            = 1'b0;
  assign out_valid       = out_valid_r;
  assign out_red_level   = red_r;
  assign out_green_level = green_r;
  assign out_blue_level  = blue_r;

  assign hd_chk    = hd_r[HDIV_ST].vld && (segment_step_r != '0);
  assign hd_rem_ok = hd_r[HDIV_ST].rem < segment_step_r;
  assign cd_chk    = cd_r[CDIV_ST].vld && !cd_r[CDIV_ST].sat;
  assign cd_sat    = cd_r[CDIV_ST].vld && cd_r[CDIV_ST].sat;
  assign cd_rem_ok = (cd_r[CDIV_ST].ch[0].rem < segment_step_r) &&
                     (cd_r[CDIV_ST].ch[1].rem < segment_step_r) &&
                     (cd_r[CDIV_ST].ch[2].rem < segment_step_r);
  assign out_rgb   = {out_red_level, out_green_level, out_blue_level};

  `HCR_ASSERT_IMP(a_hdiv_rem, hd_chk, hd_rem_ok, "height remainder not below step")
  `HCR_ASSERT_IMP(a_cdiv_rem, cd_chk, cd_rem_ok, "channel remainder not below step")
  `HCR_ASSERT_NEXT(a_sat_out, cd_sat, out_valid && (out_rgb == palette_r[last_idx]), "bad sat word")

endmodule
